[hdl/scs_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the moving-average crossover signal block.
// Used by every module under hdl; depends on nothing else.
package scs_pkg;

    // Fixed field widths.
    localparam int INST_W  = 4;
    localparam int PRICE_W = 32;
    localparam int SUM_W   = 38;
    localparam int CFG_W   = 7;

    // Default parameter values.
    localparam int DEF_NUM_INSTRUMENTS = 16;
    localparam int DEF_MAX_WINDOW      = 64;

    // Price selection codes.
    localparam logic [2:0] MODE_CLOSE = 3'd0;
    localparam logic [2:0] MODE_OPEN  = 3'd1;
    localparam logic [2:0] MODE_HIGH  = 3'd2;
    localparam logic [2:0] MODE_LOW   = 3'd3;
    localparam logic [2:0] MODE_HLC3  = 3'd4;
    localparam logic [2:0] MODE_OHLC4 = 3'd5;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_SHORT = 2'd0;
    localparam logic [1:0] REG_LONG  = 2'd1;
    localparam logic [1:0] REG_MODE  = 2'd2;
    localparam logic [1:0] REG_MASK  = 2'd3;

    // Reciprocal of three, ceil(2^35 / 3), split in two halves for the multiply.
    localparam int          DIV3_SHIFT = 35;
    localparam logic [16:0] DIV3_LO    = 17'h0AAAB;
    localparam logic [16:0] DIV3_HI    = 17'h15555;

    // One classified tick on its way from the front end to the engine.
    typedef struct packed {
        logic [INST_W-1:0]  inst;
        logic [PRICE_W-1:0] price;
    } t_item;

endpackage

[hdl/sma_crossover_signal.sv]
`timescale 1ns / 1ps
// Top level of the moving-average crossover signal block: configuration
// registers, front end, queue and engine. Depends on scs_pkg and its modules.
//
// Usage: ticks enter on i_valid/o_ready with the instrument index and the bid,
// ask and last prices; a request is taken when both are high. Ticks for an
// instrument outside the configured count are dropped. Orders leave on
// o_valid/i_ready, at most one per tick, held in an output register until taken.
// The front end selects the price in a registered pipeline and hands the tick
// to a four-entry queue, so it keeps accepting while the engine is busy.
// When the instrument's window sums are current, the engine handles a tick in
// steps: a ring read, the sum update, the cross multiply and the decision; the
// last two only once the long window is full. After reset or a write to either
// window register, the first tick of each instrument rebuilds its sums by
// reading the ring one entry a cycle, up to the long window length. If the
// receiver stalls, the engine waits at its decision, then the queue and the
// front end fill and o_ready falls. Reset clears all control state and sets the
// order number to one; the user must write configuration over the APB port only
// while idle, as the block does not enforce it.
module sma_crossover_signal import scs_pkg::*; #(
    parameter int NUM_INSTRUMENTS = DEF_NUM_INSTRUMENTS,
    parameter int MAX_WINDOW      = DEF_MAX_WINDOW
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [INST_W-1:0]  i_instrument_index,
    input  logic [PRICE_W-1:0] i_bid_level,
    input  logic [PRICE_W-1:0] i_ask_level,
    input  logic [PRICE_W-1:0] i_last_level,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_order_number,
    output logic [INST_W-1:0]  o_order_instrument,
    output logic               o_order_side,
    output logic [PRICE_W-1:0] o_order_price,
    output logic signed [31:0] o_held_quantity,
    output logic [31:0]        o_trades_done,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int WW = $clog2(MAX_WINDOW + 1);

    logic [CFG_W-1:0] r_short, r_long;
    logic [2:0]       r_mode;
    logic [3:0]       r_mask;
    logic             wr_en;
    logic [1:0]       reg_idx;
    logic [WW-1:0]    lw, sw;
    logic             push, push_ready, q_valid, q_pop;
    t_item            push_item, q_item;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short <= CFG_W'(5);
            r_long  <= CFG_W'(20);
            r_mode  <= MODE_CLOSE;
            r_mask  <= 4'hF;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SHORT: r_short <= pwdata[CFG_W-1:0];
                REG_LONG:  r_long  <= pwdata[CFG_W-1:0];
                REG_MODE:  r_mode  <= pwdata[2:0];
                REG_MASK:  r_mask  <= pwdata[3:0];
                default:   r_mask  <= r_mask;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (reg_idx)
            REG_SHORT: prdata = 32'(r_short);
            REG_LONG:  prdata = 32'(r_long);
            REG_MODE:  prdata = 32'(r_mode);
            REG_MASK:  prdata = 32'(r_mask);
            default:   prdata = '0;
        endcase
    end

    // Window lengths clamped to their legal ranges.
    always_comb begin
        if (r_long == '0)                       lw = WW'(1);
        else if (32'(r_long) > MAX_WINDOW)      lw = WW'(MAX_WINDOW);
        else                                    lw = WW'(r_long);
        if (r_short == '0)                      sw = WW'(1);
        else if (32'(r_short) > 32'(lw))        sw = lw;
        else                                    sw = WW'(r_short);
    end

    scs_front #(
        .NUM_INSTRUMENTS(NUM_INSTRUMENTS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_instrument_index(i_instrument_index),
        .i_bid_level       (i_bid_level),
        .i_ask_level       (i_ask_level),
        .i_last_level      (i_last_level),
        .i_mode            (r_mode),
        .i_mask            (r_mask),
        .o_push            (push),
        .o_item            (push_item),
        .i_push_ready      (push_ready)
    );

    scs_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (push_item),
        .o_not_full(push_ready),
        .o_valid   (q_valid),
        .o_item    (q_item),
        .i_pop     (q_pop)
    );

    scs_engine #(
        .NUM_INSTRUMENTS(NUM_INSTRUMENTS),
        .MAX_WINDOW     (MAX_WINDOW)
    ) u_engine (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_item          (q_item),
        .o_q_pop           (q_pop),
        .i_lw              (lw),
        .i_sw              (sw),
        .i_win_wr          (wr_en && (reg_idx == REG_SHORT || reg_idx == REG_LONG)),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_order_number    (o_order_number),
        .o_order_instrument(o_order_instrument),
        .o_order_side      (o_order_side),
        .o_order_price     (o_order_price),
        .o_held_quantity   (o_held_quantity),
        .o_trades_done     (o_trades_done)
    );

endmodule

[hdl/scs_front.sv]
`timescale 1ns / 1ps
// Front end: accepts ticks, drops unknown instruments and selects the price.
// Depends on scs_pkg.
module scs_front import scs_pkg::*; #(
    parameter int NUM_INSTRUMENTS = DEF_NUM_INSTRUMENTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [INST_W-1:0]  i_instrument_index,
    input  logic [PRICE_W-1:0] i_bid_level,
    input  logic [PRICE_W-1:0] i_ask_level,
    input  logic [PRICE_W-1:0] i_last_level,
    input  logic [2:0]         i_mode,
    input  logic [3:0]         i_mask,
    output logic               o_push,
    output t_item              o_item,
    input  logic               i_push_ready
);

    logic               r1_valid, r2_valid;
    logic [INST_W-1:0]  r1_inst, r2_inst;
    logic               r1_div, r2_div;
    logic [PRICE_W-1:0] r1_plain, r2_plain;
    logic [33:0]        r1_x;
    logic [50:0]        r2_plo, r2_phi;
    logic               stage_en;
    logic               in_range;
    logic               n_div;
    logic [PRICE_W-1:0] n_plain;
    logic [33:0]        n_x;
    logic [33:0]        ohlc_sum;
    logic [67:0]        quot_full;

    // The pipeline moves whenever its last stage is empty or being drained.
    assign stage_en = !r2_valid || i_push_ready;
    assign o_ready  = stage_en;
    assign in_range = 32'(i_instrument_index) < NUM_INSTRUMENTS;

    // Price selection; the three-way average goes on to the reciprocal multiply.
    always_comb begin
        ohlc_sum = 34'(i_ask_level) + {1'b0, i_bid_level, 1'b0} + 34'(i_last_level);
        n_div    = 1'b0;
        n_x      = 34'(i_ask_level) + 34'(i_bid_level) + 34'(i_last_level);
        n_plain  = i_last_level;
        unique case (i_mode)
            MODE_CLOSE: n_plain = i_last_level;
            MODE_OPEN:  n_plain = i_mask[1] ? i_bid_level : i_last_level;
            MODE_HIGH:  n_plain = i_mask[2] ? i_ask_level : i_last_level;
            MODE_LOW:   n_plain = i_mask[3] ? i_bid_level : i_last_level;
            MODE_HLC3:  n_div   = 1'b1;
            MODE_OHLC4: n_plain = ohlc_sum[33:2];
            default:    n_plain = i_last_level;
        endcase
    end

    // Stage one registers the selection, stage two the partial products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (stage_en) begin
            r1_valid <= i_valid && in_range;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en) begin
            r1_inst  <= i_instrument_index;
            r1_div   <= n_div;
            r1_plain <= n_plain;
            r1_x     <= n_x;
            r2_inst  <= r1_inst;
            r2_div   <= r1_div;
            r2_plain <= r1_plain;
            r2_plo   <= 51'(r1_x) * 51'(DIV3_LO);
            r2_phi   <= 51'(r1_x) * 51'(DIV3_HI);
        end
    end

    assign quot_full   = (68'(r2_phi) << 17) + 68'(r2_plo);
    assign o_push      = r2_valid;
    assign o_item.inst = r2_inst;
    assign o_item.price = r2_div ? quot_full[DIV3_SHIFT +: PRICE_W] : r2_plain;

endmodule

[hdl/scs_fifo.sv]
`timescale 1ns / 1ps
// Short queue of classified ticks between the front end and the engine.
// Depends on scs_pkg.
module scs_fifo import scs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_not_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    localparam int DEPTH = 4;

    t_item      r_mem [DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       do_push, do_pop;

    assign o_not_full = r_cnt != 3'(DEPTH);
    assign o_valid    = r_cnt != 3'd0;
    assign o_item     = r_mem[r_rp];
    assign do_push    = i_push && o_not_full;
    assign do_pop     = i_pop && o_valid;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 2'd1;
            if (do_pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(do_push) - 3'(do_pop);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_item;
    end

endmodule

[hdl/scs_engine.sv]
`timescale 1ns / 1ps
// Back end: price ring, window sums, crossover decision and order output.
// Depends on scs_pkg.
module scs_engine import scs_pkg::*; #(
    parameter int NUM_INSTRUMENTS = DEF_NUM_INSTRUMENTS,
    parameter int MAX_WINDOW      = DEF_MAX_WINDOW
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_item              i_q_item,
    output logic               o_q_pop,
    input  logic [$clog2(MAX_WINDOW+1)-1:0] i_lw,
    input  logic [$clog2(MAX_WINDOW+1)-1:0] i_sw,
    input  logic               i_win_wr,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_order_number,
    output logic [INST_W-1:0]  o_order_instrument,
    output logic               o_order_side,
    output logic [PRICE_W-1:0] o_order_price,
    output logic signed [31:0] o_held_quantity,
    output logic [31:0]        o_trades_done
);

    localparam int IW    = (NUM_INSTRUMENTS > 1) ? $clog2(NUM_INSTRUMENTS) : 1;
    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int WW    = $clog2(MAX_WINDOW + 1);
    localparam int DEPTH = NUM_INSTRUMENTS * MAX_WINDOW;
    localparam int MAW   = $clog2(DEPTH);
    localparam int PW    = SUM_W + WW;

    typedef enum logic [2:0] {S_IDLE, S_SUM, S_SWEEP, S_MUL, S_DEC} t_state;

    t_state r_state;

    // Per-instrument state.
    logic [AW-1:0]     r_pos  [NUM_INSTRUMENTS];
    logic [WW-1:0]     r_fill [NUM_INSTRUMENTS];
    logic              r_held [NUM_INSTRUMENTS];
    logic signed [31:0] r_qty [NUM_INSTRUMENTS];
    logic              r_sval [NUM_INSTRUMENTS];
    logic [SUM_W-1:0]  r_lsum [NUM_INSTRUMENTS];
    logic [SUM_W-1:0]  r_ssum [NUM_INSTRUMENTS];

    // Price ring.
    logic [PRICE_W-1:0] r_ring [DEPTH];
    logic [PRICE_W-1:0] r_rda, r_rdb;

    // Working registers of the item in flight.
    logic [IW-1:0]      r_idx;
    logic [INST_W-1:0]  r_inst;
    logic [PRICE_W-1:0] r_price;
    logic [WW-1:0]      r_fill_old, r_fill_new;
    logic [SUM_W-1:0]   r_lsum_cur, r_ssum_cur;
    logic [AW-1:0]      r_cidx;
    logic [WW-1:0]      r_cnt;
    logic               r_rdv, r_rds;
    logic [PW-1:0]      r_lhs, r_rhs;
    logic [31:0]        r_next_num, r_trades;

    logic [IW-1:0]      q_idx;
    logic [AW-1:0]      cur_pos, pos_next;
    logic [AW:0]        ev_l, ev_s;
    logic [WW:0]        fill_inc;
    logic [WW-1:0]      fill_new;
    logic [MAW-1:0]     base_q, base_r, addr_a, addr_b, addr_w;
    logic [SUM_W-1:0]   long_new, short_new;
    logic               held_now, buy, sell, out_free;
    logic signed [31:0] qty_now, qty_new;

    assign q_idx   = IW'(i_q_item.inst);
    assign cur_pos = r_pos[q_idx];
    assign pos_next = (32'(cur_pos) == MAX_WINDOW - 1) ? '0 : cur_pos + AW'(1);

    // Ring slots that leave the long and short windows, modulo the ring length.
    always_comb begin
        ev_l = (cur_pos >= AW'(i_lw)) ? (AW+1)'(cur_pos) - (AW+1)'(i_lw)
                                     : (AW+1)'(cur_pos) + (AW+1)'(MAX_WINDOW) - (AW+1)'(i_lw);
        ev_s = (cur_pos >= AW'(i_sw)) ? (AW+1)'(cur_pos) - (AW+1)'(i_sw)
                                     : (AW+1)'(cur_pos) + (AW+1)'(MAX_WINDOW) - (AW+1)'(i_sw);
        if ({1'b0, i_lw} == (WW+1)'(MAX_WINDOW)) ev_l = (AW+1)'(cur_pos);
        if ({1'b0, i_sw} == (WW+1)'(MAX_WINDOW)) ev_s = (AW+1)'(cur_pos);
    end

    assign fill_inc = (WW+1)'(r_fill[q_idx]) + (WW+1)'(1);
    assign fill_new = (fill_inc > (WW+1)'(i_lw)) ? i_lw : WW'(fill_inc);

    assign base_q = MAW'(q_idx) * MAW'(MAX_WINDOW);
    assign base_r = MAW'(r_idx) * MAW'(MAX_WINDOW);
    assign addr_w = base_q + MAW'(cur_pos);
    assign addr_a = (r_state == S_IDLE) ? base_q + MAW'(ev_l[AW-1:0]) : base_r + MAW'(r_cidx);
    assign addr_b = base_q + MAW'(ev_s[AW-1:0]);
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    // Incremental sums: add the new price, drop the slot that left each window.
    assign long_new  = r_lsum_cur + SUM_W'(r_price)
                       - ((r_fill_old == i_lw) ? SUM_W'(r_rda) : '0);
    assign short_new = r_ssum_cur + SUM_W'(r_price)
                       - ((r_fill_old >= i_sw) ? SUM_W'(r_rdb) : '0);

    // Crossover decision with hysteresis.
    assign held_now = r_held[r_idx];
    assign qty_now  = r_qty[r_idx];
    assign buy      = !held_now && (r_lhs > r_rhs);
    assign sell     = held_now && (r_lhs < r_rhs);
    assign out_free = !o_valid || i_ready;
    always_comb begin
        qty_new = qty_now;
        if (buy && qty_now != 32'sh7FFFFFFF) qty_new = qty_now + 32'sd1;
        if (sell && qty_now != 32'sh80000000) qty_new = qty_now - 32'sd1;
    end

    // Ring memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_ring[addr_w] <= i_q_item.price;
        r_rda <= r_ring[addr_a];
        r_rdb <= r_ring[addr_b];
    end

    // Sums are payload; their valid flags sit in the control block below.
    always_ff @(posedge i_clk) begin
        if (r_state == S_SUM) begin
            r_lsum[r_idx] <= long_new;
            r_ssum[r_idx] <= short_new;
        end else if (r_state == S_SWEEP && r_cnt == r_fill_new && !r_rdv) begin
            r_lsum[r_idx] <= r_lsum_cur;
            r_ssum[r_idx] <= r_ssum_cur;
        end
    end

    // Sequencer, per-instrument control state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_next_num <= 32'd1;
            r_trades   <= '0;
            o_valid    <= 1'b0;
            r_rdv      <= 1'b0;
            for (int i = 0; i < NUM_INSTRUMENTS; i++) begin
                r_pos[i]  <= '0;
                r_fill[i] <= '0;
                r_held[i] <= 1'b0;
                r_qty[i]  <= '0;
                r_sval[i] <= 1'b0;
            end
        end else begin
            // A taken order clears the output unless a new one replaces it at once.
            if (o_valid && i_ready && !(r_state == S_DEC && (buy || sell))) begin
                o_valid <= 1'b0;
            end
            if (i_win_wr) begin
                for (int i = 0; i < NUM_INSTRUMENTS; i++) r_sval[i] <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_idx        <= q_idx;
                        r_inst       <= i_q_item.inst;
                        r_price      <= i_q_item.price;
                        r_fill_old   <= r_fill[q_idx];
                        r_fill_new   <= fill_new;
                        r_pos[q_idx] <= pos_next;
                        r_fill[q_idx] <= fill_new;
                        r_cidx       <= cur_pos;
                        r_cnt        <= '0;
                        r_rdv        <= 1'b0;
                        if (r_sval[q_idx]) begin
                            r_lsum_cur <= r_lsum[q_idx];
                            r_ssum_cur <= r_ssum[q_idx];
                            r_state    <= S_SUM;
                        end else begin
                            r_lsum_cur <= '0;
                            r_ssum_cur <= '0;
                            r_state    <= S_SWEEP;
                        end
                    end
                end
                S_SUM: begin
                    r_lsum_cur <= long_new;
                    r_ssum_cur <= short_new;
                    r_state    <= (r_fill_new < i_lw) ? S_IDLE : S_MUL;
                end
                S_SWEEP: begin
                    // One ring read a cycle, newest first; its data lands in the next cycle.
                    if (r_rdv) begin
                        r_lsum_cur <= r_lsum_cur + SUM_W'(r_rda);
                        if (r_rds) r_ssum_cur <= r_ssum_cur + SUM_W'(r_rda);
                    end
                    if (r_cnt != r_fill_new) begin
                        r_rdv  <= 1'b1;
                        r_rds  <= r_cnt < i_sw;
                        r_cnt  <= r_cnt + WW'(1);
                        r_cidx <= (r_cidx == '0) ? AW'(MAX_WINDOW - 1) : r_cidx - AW'(1);
                    end else begin
                        r_rdv <= 1'b0;
                        if (!r_rdv) begin
                            r_sval[r_idx] <= 1'b1;
                            r_state <= (r_fill_new < i_lw) ? S_IDLE : S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_lhs   <= PW'(r_ssum_cur) * PW'(i_lw);
                    r_rhs   <= PW'(r_lsum_cur) * PW'(i_sw);
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    if (!(buy || sell)) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        r_held[r_idx]      <= buy;
                        r_qty[r_idx]       <= qty_new;
                        r_next_num         <= r_next_num + 32'd1;
                        if (r_trades != '1) r_trades <= r_trades + 32'd1;
                        o_valid            <= 1'b1;
                        o_order_number     <= r_next_num;
                        o_order_instrument <= r_inst;
                        o_order_side       <= sell;
                        o_order_price      <= r_price;
                        o_held_quantity    <= qty_new;
                        o_trades_done      <= (r_trades != '1) ? r_trades + 32'd1 : r_trades;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The sweep never reads more entries than the window holds.
    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (r_cnt <= r_fill_new))
        else $error("ring sweep ran past the fill level");

    // A decision is only reached with a full long window.
    a_full_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_fill_new == i_lw))
        else $error("comparison started before the window filled");

    // Every order issued advances the order number by exactly one.
    a_order_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC && (buy || sell) && out_free)
        |=> (r_next_num == $past(r_next_num) + 32'd1) && o_valid)
        else $error("order number did not advance with an order");

    // The queue is drained only while idle, and each tick taken starts its sum update.
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == S_SUM || r_state == S_SWEEP))
        else $error("tick taken without starting its update");

endmodule

[tb/sma_crossover_signal_checker.sv]
`timescale 1ns / 1ps
// Order checker for the crossover signal block: follows the tick and order channels
// and the APB writes, predicts each order and compares it. Depends on scs_pkg.
module sma_crossover_signal_checker import scs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic [INST_W-1:0]  i_instrument_index,
    input  logic [PRICE_W-1:0] i_bid_level,
    input  logic [PRICE_W-1:0] i_ask_level,
    input  logic [PRICE_W-1:0] i_last_level,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic [31:0]        o_order_number,
    input  logic [INST_W-1:0]  o_order_instrument,
    input  logic               o_order_side,
    input  logic [PRICE_W-1:0] o_order_price,
    input  logic signed [31:0] o_held_quantity,
    input  logic [31:0]        o_trades_done,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 o_fail_count,
    output int                 o_orders_pending
);

    localparam int NINST = DEF_NUM_INSTRUMENTS;
    localparam int WIN   = DEF_MAX_WINDOW;

    typedef struct {
        logic [31:0]        number;
        logic [INST_W-1:0]  inst;
        logic               side;
        logic [31:0]        price;
        logic signed [31:0] qty;
        logic [31:0]        trades;
    } t_order;

    // Mirror of the block's state and registers.
    logic [31:0]        ring [NINST][WIN];
    logic [5:0]         wr_pos [NINST];
    logic [6:0]         filled [NINST];
    logic [SUM_W-1:0]   long_acc [NINST];
    logic [SUM_W-1:0]   short_acc [NINST];
    logic               holding [NINST];
    logic signed [31:0] position [NINST];
    logic [31:0]        order_no;
    logic [31:0]        trade_cnt;
    logic [6:0]         cfg_short;
    logic [6:0]         cfg_long;
    logic [2:0]         cfg_mode;
    logic [3:0]         cfg_mask;

    t_order expected_orders[$];
    int     fails;

    assign o_fail_count     = fails;
    assign o_orders_pending = expected_orders.size();

    function automatic logic [31:0] select_price(logic [31:0] bid, logic [31:0] ask,
                                                 logic [31:0] last);
        logic [63:0] acc;
        acc = 64'd0;
        case (cfg_mode)
            MODE_CLOSE: return last;
            MODE_OPEN:  return cfg_mask[1] ? bid : last;
            MODE_HIGH:  return cfg_mask[2] ? ask : last;
            MODE_LOW:   return cfg_mask[3] ? bid : last;
            MODE_HLC3: begin
                acc = (64'(ask) + 64'(bid) + 64'(last)) / 64'd3;
                return acc[31:0];
            end
            MODE_OHLC4: begin
                acc = (64'(ask) + 64'(bid) + 64'(bid) + 64'(last)) / 64'd4;
                return acc[31:0];
            end
            default:    return last;
        endcase
    endfunction

    // Sum of the newest count prices of one instrument, held at the sum width.
    function automatic logic [SUM_W-1:0] recent_sum(int inst, int count);
        logic [63:0] acc;
        logic [5:0]  idx;
        acc = 64'd0;
        for (int i = 0; i < count; i++) begin
            idx = wr_pos[inst] - 6'd1 - 6'(i);
            acc = acc + 64'(ring[inst][idx]);
        end
        return acc[SUM_W-1:0];
    endfunction

    task automatic predict_tick(int inst, logic [31:0] bid, logic [31:0] ask,
                                logic [31:0] last);
        int          lw;
        int          sw;
        logic [31:0] price;
        logic [63:0] lhs;
        logic [63:0] rhs;
        logic        buy;
        t_order      ord;
        lw = cfg_long;
        if (lw < 1) lw = 1;
        if (lw > WIN) lw = WIN;
        sw = cfg_short;
        if (sw < 1) sw = 1;
        if (sw > lw) sw = lw;
        price = select_price(bid, ask, last);
        ring[inst][wr_pos[inst]] = price;
        wr_pos[inst] = wr_pos[inst] + 6'd1;
        if (int'(filled[inst]) + 1 > lw) filled[inst] = 7'(lw);
        else filled[inst] = filled[inst] + 7'd1;
        long_acc[inst]  = recent_sum(inst, filled[inst]);
        short_acc[inst] = recent_sum(inst, (int'(filled[inst]) < sw) ? filled[inst] : sw);
        if (int'(filled[inst]) < lw) return;
        lhs = 64'(short_acc[inst]) * 64'(lw);
        rhs = 64'(long_acc[inst]) * 64'(sw);
        if (!holding[inst] && lhs > rhs) begin
            buy = 1'b1;
            holding[inst] = 1'b1;
        end else if (holding[inst] && lhs < rhs) begin
            buy = 1'b0;
            holding[inst] = 1'b0;
        end else begin
            return;
        end
        if (buy && position[inst] != 32'sh7FFFFFFF) position[inst] = position[inst] + 1;
        if (!buy && position[inst] != 32'sh80000000) position[inst] = position[inst] - 1;
        if (trade_cnt != 32'hFFFFFFFF) trade_cnt = trade_cnt + 32'd1;
        ord.number = order_no;
        ord.inst   = INST_W'(inst);
        ord.side   = !buy;
        ord.price  = price;
        ord.qty    = position[inst];
        ord.trades = trade_cnt;
        expected_orders.insert(expected_orders.size(), ord);
        order_no = order_no + 32'd1;
    endtask

    task automatic compare_order();
        t_order exp_ord;
        if (expected_orders.size() == 0) begin
            $error("unexpected order number %0d", o_order_number);
            fails++;
            return;
        end
        exp_ord = expected_orders.pop_front();
        if (o_order_number !== exp_ord.number) begin
            $error("order_number expected %0d actual %0d", exp_ord.number, o_order_number);
            fails++;
        end
        if (o_order_instrument !== exp_ord.inst) begin
            $error("order_instrument expected %0d actual %0d", exp_ord.inst,
                   o_order_instrument);
            fails++;
        end
        if (o_order_side !== exp_ord.side) begin
            $error("order_side expected %0d actual %0d", exp_ord.side, o_order_side);
            fails++;
        end
        if (o_order_price !== exp_ord.price) begin
            $error("order_price expected %0d actual %0d", exp_ord.price, o_order_price);
            fails++;
        end
        if (o_held_quantity !== exp_ord.qty) begin
            $error("held_quantity expected %0d actual %0d", exp_ord.qty, o_held_quantity);
            fails++;
        end
        if (o_trades_done !== exp_ord.trades) begin
            $error("trades_done expected %0d actual %0d", exp_ord.trades, o_trades_done);
            fails++;
        end
    endtask

    initial fails = 0;

    // Orders are compared before the tick of the same edge is predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NINST; i++) begin
                wr_pos[i]    = 6'd0;
                filled[i]    = 7'd0;
                long_acc[i]  = '0;
                short_acc[i] = '0;
                holding[i]   = 1'b0;
                position[i]  = 32'sd0;
            end
            order_no  = 32'd1;
            trade_cnt = 32'd0;
            cfg_short = 7'd5;
            cfg_long  = 7'd20;
            cfg_mode  = MODE_CLOSE;
            cfg_mask  = 4'hF;
        end else begin
            if (o_valid && i_ready) compare_order();
            if (i_valid && o_ready)
                predict_tick(i_instrument_index, i_bid_level, i_ask_level, i_last_level);
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_SHORT: cfg_short = pwdata[6:0];
                    REG_LONG:  cfg_long  = pwdata[6:0];
                    REG_MODE:  cfg_mode  = pwdata[2:0];
                    REG_MASK:  cfg_mask  = pwdata[3:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

[tb/tb_sma_crossover_signal.sv]
`timescale 1ns / 1ps
// Testbench top for the crossover signal block: clock, reset, tick and APB stimulus
// and the verdict. Depends on scs_pkg, the block and sma_crossover_signal_checker.
module tb_sma_crossover_signal import scs_pkg::*;;

    localparam int SETTLE_CYCLES = 600;
    localparam int CYCLE_LIMIT   = 2000000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [INST_W-1:0]  i_instrument_index;
    logic [PRICE_W-1:0] i_bid_level;
    logic [PRICE_W-1:0] i_ask_level;
    logic [PRICE_W-1:0] i_last_level;
    logic               o_valid;
    logic               i_ready;
    logic [31:0]        o_order_number;
    logic [INST_W-1:0]  o_order_instrument;
    logic               o_order_side;
    logic [PRICE_W-1:0] o_order_price;
    logic signed [31:0] o_held_quantity;
    logic [31:0]        o_trades_done;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int          fail_count;
    int          orders_pending;
    int          cycles;
    int          stall_left;
    bit          smooth;
    logic [31:0] mid_price [16];
    bit          rising [16];

    sma_crossover_signal dut (.*);

    sma_crossover_signal_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_instrument_index, .i_bid_level,
        .i_ask_level, .i_last_level, .o_valid, .i_ready, .o_order_number,
        .o_order_instrument, .o_order_side, .o_order_price, .o_held_quantity,
        .o_trades_done, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_orders_pending(orders_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run-away guard.
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: a random stall before each order is taken, unless smooth is set.
    initial stall_left = 0;
    always @(negedge i_clk) begin
        if (smooth || stall_left == 0) i_ready <= 1'b1;
        else i_ready <= 1'b0;
    end
    always @(posedge i_clk) begin
        if (o_valid && i_ready) stall_left <= $urandom_range(0, 4);
        else if (stall_left > 0) stall_left <= stall_left - 1;
    end

    // Setup and access phases followed by an idle phase, so that writes never share a falling edge.
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Stops sending, then waits until every order has arrived and any order-less
    // tick has drained.
    task automatic drain();
        i_valid <= 1'b0;
        while (orders_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(logic [6:0] sw, logic [6:0] lw, logic [2:0] mode,
                             logic [3:0] mask);
        drain();
        write_reg(REG_SHORT, 32'(sw) | ($urandom & 32'hFFFFFF80));
        write_reg(REG_LONG, 32'(lw));
        write_reg(REG_MODE, 32'(mode));
        write_reg(REG_MASK, 32'(mask));
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_tick(logic [3:0] inst, logic [31:0] bid, logic [31:0] ask,
                             logic [31:0] last);
        int gap;
        gap = smooth ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid            <= 1'b1;
        i_instrument_index <= inst;
        i_bid_level        <= bid;
        i_ask_level        <= ask;
        i_last_level       <= last;
        #1;
        while (!o_ready) begin
            @(negedge i_clk);
            #1;
        end
        @(negedge i_clk);
    endtask

    // A trending tick on one instrument, with the odd wholly random request.
    task automatic market_tick(logic [3:0] inst);
        logic [31:0] step;
        logic [31:0] spread;
        if ($urandom_range(0, 9) == 0) begin
            send_tick(inst, $urandom, $urandom, $urandom);
            return;
        end
        if ($urandom_range(0, 7) == 0) rising[inst] = !rising[inst];
        step = $urandom_range(0, 800);
        if (rising[inst] && mid_price[inst] < 32'd4000000000) mid_price[inst] += step;
        else if (mid_price[inst] > 32'd100000) mid_price[inst] -= step;
        spread = $urandom_range(0, 300);
        send_tick(inst, mid_price[inst] - spread, mid_price[inst] + spread,
                  mid_price[inst] + $urandom_range(0, 200) - 100);
    endtask

    task automatic random_phase(int items);
        logic [6:0] lw;
        int         span;
        lw = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(13, 127))
                                         : 7'($urandom_range(0, 12));
        configure(7'($urandom_range(0, 14)), lw, 3'($urandom_range(0, 7)),
                  4'($urandom_range(0, 15)));
        smooth = ($urandom_range(0, 3) == 0);
        span   = (lw > 12) ? 0 : $urandom_range(0, 3);
        if (span == 3) span = 15;
        for (int n = 0; n < items; n++) market_tick(4'($urandom_range(0, span)));
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_instrument_index = '0;
        i_bid_level        = '0;
        i_ask_level        = '0;
        i_last_level       = '0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        i_ready            = 1'b1;
        smooth             = 1'b0;
        for (int i = 0; i < 16; i++) begin
            mid_price[i] = 32'd1000000 + 32'($urandom_range(0, 100000));
            rising[i]    = bit'($urandom_range(0, 1));
        end
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: a two-tick window with up- and down-crosses at the price extremes.
        configure(7'd1, 7'd2, MODE_CLOSE, 4'hF);
        send_tick(4'd0, 32'd0, 32'd0, 32'd100);
        send_tick(4'd0, 32'd0, 32'd0, 32'd200);
        send_tick(4'd0, 32'd0, 32'd0, 32'd100);
        send_tick(4'd0, 32'd0, 32'd0, 32'd0);
        send_tick(4'd0, 32'd0, 32'd0, 32'hFFFFFFFF);
        send_tick(4'd0, 32'd0, 32'd0, 32'd0);
        // Averaged modes with all-ones prices, where the sums exceed 32 bits.
        configure(7'd1, 7'd1, MODE_HLC3, 4'h0);
        send_tick(4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_tick(4'd15, 32'hFFFFFFFF, 32'hFFFFFFFE, 32'h00000001);
        configure(7'd0, 7'd0, MODE_OHLC4, 4'h0);
        send_tick(4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_tick(4'd15, 32'h00000003, 32'h00000000, 32'h00000002);
        // Column selection with the column present and absent, and the unused mode.
        configure(7'd127, 7'd2, MODE_OPEN, 4'h0);
        send_tick(4'd5, 32'd10, 32'd20, 32'd30);
        send_tick(4'd5, 32'd40, 32'd50, 32'd60);
        configure(7'd1, 7'd2, MODE_HIGH, 4'hF);
        send_tick(4'd5, 32'd10, 32'd90, 32'd30);
        send_tick(4'd5, 32'd10, 32'd5, 32'd30);
        configure(7'd1, 7'd2, MODE_LOW, 4'h8);
        send_tick(4'd10, 32'd70, 32'd20, 32'd30);
        send_tick(4'd10, 32'd80, 32'd20, 32'd30);
        configure(7'd1, 7'd2, 3'd7, 4'hF);
        send_tick(4'd10, 32'd70, 32'd20, 32'd10);
        send_tick(4'd10, 32'd70, 32'd20, 32'd90);

        // Random: full 64-entry windows, then mostly short windows.
        configure(7'd64, 7'd64, MODE_CLOSE, 4'hF);
        for (int n = 0; n < 150; n++) market_tick(4'd3);
        configure(7'd3, 7'd127, MODE_HLC3, 4'hF);
        for (int n = 0; n < 150; n++) market_tick(4'd7);
        for (int p = 0; p < 11; p++) random_phase(95);

        drain();
        if (fail_count == 0 && orders_pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
